>>> rtl/idw_pkg.sv
package idw_pkg;

   localparam int WEIGHT_SHIFT_DEF = 40;
   localparam int COORD_WIDTH_DEF  = 16;
   localparam int DIV_WIDTH        = 64;
   localparam int SUM_WIDTH        = 64;
   localparam int WSUM_WIDTH       = 49;
   localparam int CNT_WIDTH        = $clog2(DIV_WIDTH);

   typedef struct packed {
      logic accept;    // take the input item
      logic sq_x;      // square dx
      logic sq_y;      // square dy and form d2
      logic hit;       // record exact hit
      logic div_w;     // start weight division
      logic div_f;     // start final division
      logic div_step;  // one divider step
      logic mul_lo;    // accumulate z * weight[31:0]
      logic mul_hi;    // accumulate z * weight[63:32]
      logic emit;      // load result register, close set
   } cmd_type;

   typedef struct packed {
      logic has_sample;
      logic last;
      logic hit_seen;
      logic d2_zero;
      logic div_last;
      logic need_fdiv;
      logic slot_free;
   } sts_type;

endpackage

>>> rtl/idw_ctrl.sv
module idw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  idw_pkg::sts_type  sts,
   output idw_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DISP = 4'd1;
   localparam logic [3:0] S_SQX  = 4'd2;
   localparam logic [3:0] S_SQY  = 4'd3;
   localparam logic [3:0] S_CHK  = 4'd4;
   localparam logic [3:0] S_DIVW = 4'd5;
   localparam logic [3:0] S_MULL = 4'd6;
   localparam logic [3:0] S_MULH = 4'd7;
   localparam logic [3:0] S_LAST = 4'd8;
   localparam logic [3:0] S_DIVF = 4'd9;
   localparam logic [3:0] S_EMIT = 4'd10;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DISP;
            end
         end
         S_DISP: begin
            if (sts.has_sample && !sts.hit_seen) begin
               state_in = S_SQX;
            end else if (sts.last) begin
               state_in = S_LAST;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SQX: begin
            cmd.sq_x = 1'b1;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.sq_y = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (sts.d2_zero) begin
               cmd.hit  = 1'b1;
               state_in = sts.last ? S_LAST : S_IDLE;
            end else begin
               cmd.div_w = 1'b1;
               state_in  = S_DIVW;
            end
         end
         S_DIVW: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_MULL;
            end
         end
         S_MULL: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MULH;
         end
         S_MULH: begin
            cmd.mul_hi = 1'b1;
            state_in   = sts.last ? S_LAST : S_IDLE;
         end
         S_LAST: begin
            if (sts.need_fdiv) begin
               cmd.div_f = 1'b1;
               state_in  = S_DIVF;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_DIVF: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // hold until the result register is free
            if (sts.slot_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/idw_dp.sv
module idw_dp #(
   parameter int WEIGHT_SHIFT = idw_pkg::WEIGHT_SHIFT_DEF,
   parameter int COORD_WIDTH  = idw_pkg::COORD_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  idw_pkg::cmd_type    cmd,
   output idw_pkg::sts_type    sts,
   input  logic                req_has_sample,
   input  logic signed [15:0]  req_sample_x,
   input  logic signed [15:0]  req_sample_y,
   input  logic signed [15:0]  req_sample_z,
   input  logic signed [15:0]  req_query_x,
   input  logic signed [15:0]  req_query_y,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [15:0]  rsp_value,
   output logic                rsp_status,
   output logic                rsp_exact_hit
);

   localparam int CW   = COORD_WIDTH;
   localparam int SQW  = 2 * CW + 1;
   localparam int D2W  = 2 * CW + 2;
   localparam int DW   = idw_pkg::DIV_WIDTH;
   localparam int SW   = idw_pkg::SUM_WIDTH;
   localparam int WW   = idw_pkg::WSUM_WIDTH;
   localparam int CNTW = idw_pkg::CNT_WIDTH;
   localparam logic [DW-1:0] WEIGHT_NUM = DW'(1) << WEIGHT_SHIFT;

   // item fields
   logic              has_sample_ff, last_ff;
   logic [CW-1:0]     sx_ff, sy_ff;
   logic [15:0]       z_ff;
   // set state
   logic              in_set_ff, in_set_in;
   logic              seen_ff, seen_in;
   logic              hit_ff, hit_in;
   logic [15:0]       hit_val_ff, hit_val_in;
   logic [CW-1:0]     qx_ff, qy_ff;
   logic [SW-1:0]     wsum_ff, wsum_in;
   logic [WW-1:0]     wtsum_ff, wtsum_in;
   // squarer
   logic [SQW-1:0]    sq_ff;
   logic [D2W-1:0]    d2_ff;
   logic signed [CW:0]     dx, dy, sq_op;
   logic signed [2*CW+1:0] sq_full;
   // divider
   logic [DW-1:0]     num_ff, num_in;
   logic [DW-1:0]     den_ff, den_in;
   logic [DW:0]       rem_ff, rem_in;
   logic [DW-1:0]     q_ff, q_in;
   logic [CNTW-1:0]   cnt_ff, cnt_in;
   logic [DW:0]       shifted;
   logic [DW+1:0]     diff;
   logic [DW-1:0]     wmag;
   // multiplier
   logic [31:0]       mop;
   logic signed [16:0] z17;
   logic signed [49:0] prod;
   logic [SW-1:0]     p64, addend;
   // result
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       value_ff, value_calc;
   logic              status_ff, exact_ff;
   logic              wneg;

   assign dx    = $signed({sx_ff[CW-1], sx_ff}) - $signed({qx_ff[CW-1], qx_ff});
   assign dy    = $signed({sy_ff[CW-1], sy_ff}) - $signed({qy_ff[CW-1], qy_ff});
   assign sq_op = cmd.sq_y ? dy : dx;
   assign sq_full = sq_op * sq_op;

   assign shifted = {rem_ff[DW-1:0], num_ff[DW-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};

   assign wneg = wsum_ff[SW-1];
   assign wmag = wneg ? (DW'(0) - wsum_ff) : wsum_ff;

   assign mop    = cmd.mul_hi ? q_ff[63:32] : q_ff[31:0];
   assign z17    = $signed({z_ff[15], z_ff});
   assign prod   = z17 * $signed({1'b0, mop});
   assign p64    = {{(SW - 50){prod[49]}}, prod};
   assign addend = cmd.mul_hi ? {p64[31:0], 32'd0} : p64;

   always_comb begin
      in_set_in = in_set_ff;
      seen_in   = seen_ff;
      hit_in    = hit_ff;
      hit_val_in = hit_val_ff;
      wsum_in   = wsum_ff;
      wtsum_in  = wtsum_ff;
      priority if (cmd.accept) begin
         in_set_in = 1'b1;
         if (!in_set_ff) begin
            // first item of a set: clear sums and flags
            seen_in    = req_has_sample;
            hit_in     = 1'b0;
            hit_val_in = '0;
            wsum_in    = '0;
            wtsum_in   = '0;
         end else begin
            seen_in = seen_ff | req_has_sample;
         end
      end else if (cmd.hit) begin
         hit_in     = 1'b1;
         hit_val_in = z_ff;
      end else if (cmd.mul_lo) begin
         wsum_in  = wsum_ff + addend;
         wtsum_in = wtsum_ff + q_ff[WW-1:0];
      end else if (cmd.mul_hi) begin
         wsum_in = wsum_ff + addend;
      end else if (cmd.emit) begin
         in_set_in = 1'b0;
      end
   end

   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      priority if (cmd.div_w) begin
         num_in = WEIGHT_NUM;
         den_in = {{(DW - D2W){1'b0}}, d2_ff};
         rem_in = '0;
         cnt_in = '0;
      end else if (cmd.div_f) begin
         num_in = wmag;
         den_in = {{(DW - WW){1'b0}}, wtsum_ff};
         rem_in = '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         num_in = {num_ff[DW-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (!diff[DW+1]) begin
            rem_in = diff[DW:0];
            q_in   = {q_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            q_in   = {q_ff[DW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (!seen_ff) begin
         value_calc = '0;
      end else if (hit_ff) begin
         value_calc = hit_val_ff;
      end else if (wtsum_ff == '0) begin
         value_calc = '0;
      end else if (wneg) begin
         value_calc = (q_ff > DW'(32768)) ? 16'h8000 : (16'd0 - q_ff[15:0]);
      end else begin
         value_calc = (q_ff > DW'(32767)) ? 16'h7FFF : q_ff[15:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_set_ff    <= 1'b0;
         seen_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         hit_val_ff   <= '0;
         wsum_ff      <= '0;
         wtsum_ff     <= '0;
         qx_ff        <= '0;
         qy_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_set_ff    <= in_set_in;
         seen_ff      <= seen_in;
         hit_ff       <= hit_in;
         hit_val_ff   <= hit_val_in;
         wsum_ff      <= wsum_in;
         wtsum_ff     <= wtsum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.accept && !in_set_ff) begin
            qx_ff <= req_query_x[CW-1:0];
            qy_ff <= req_query_y[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         has_sample_ff <= req_has_sample;
         last_ff       <= req_last;
         sx_ff         <= req_sample_x[CW-1:0];
         sy_ff         <= req_sample_y[CW-1:0];
         z_ff          <= req_sample_z;
      end
      if (cmd.sq_x) begin
         sq_ff <= sq_full[SQW-1:0];
      end
      if (cmd.sq_y) begin
         d2_ff <= {1'b0, sq_ff} + {1'b0, sq_full[SQW-1:0]};
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (cmd.emit) begin
         value_ff  <= value_calc;
         status_ff <= !seen_ff;
         exact_ff  <= seen_ff && hit_ff;
      end
   end

   assign sts.has_sample = has_sample_ff;
   assign sts.last       = last_ff;
   assign sts.hit_seen   = hit_ff;
   assign sts.d2_zero    = (d2_ff == '0);
   assign sts.div_last   = (cnt_ff == '1);
   assign sts.need_fdiv  = seen_ff && !hit_ff && (wtsum_ff != '0);
   assign sts.slot_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = value_ff;
   assign rsp_status    = status_ff;
   assign rsp_exact_hit = exact_ff;

endmodule

>>> rtl/inverse_distance_interpolator.sv
// Inverse-distance interpolator, power 2, fixed point.
// Input channel req_*: one item per sample station, with the query point on
// every item; the query is latched from the first item of a set and
// req_last closes the set. An item with req_has_sample low carries no sample.
// Result channel rsp_*: one item per set, sent after the item carrying
// req_last: value, status (1 = set had no sample) and exact_hit.
// Timing: one item at a time. A sample passes dispatch, squaring of dx and
// dy, an exact-hit check, the weight division and the low and high
// multiply-accumulate; an item without a sample only dispatches. Closing a
// set adds the final division when needed, then the emit. The 64-step
// bit-serial restoring divider serves the per-sample weight and final quotient.
// The result sits in an output register, so the next item is accepted while
// it waits; a further result waits until the receiver takes it.
// Reset clears the sums, flags and held query and drops any pending result.
module inverse_distance_interpolator #(
   parameter int WEIGHT_SHIFT = idw_pkg::WEIGHT_SHIFT_DEF,
   parameter int COORD_WIDTH  = idw_pkg::COORD_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_has_sample,
   input  logic signed [15:0] req_sample_x,
   input  logic signed [15:0] req_sample_y,
   input  logic signed [15:0] req_sample_z,
   input  logic signed [15:0] req_query_x,
   input  logic signed [15:0] req_query_y,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_value,
   output logic               rsp_status,
   output logic               rsp_exact_hit
);

   idw_pkg::cmd_type cmd;
   idw_pkg::sts_type sts;

   idw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   idw_dp #(
      .WEIGHT_SHIFT (WEIGHT_SHIFT),
      .COORD_WIDTH  (COORD_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_has_sample (req_has_sample),
      .req_sample_x   (req_sample_x),
      .req_sample_y   (req_sample_y),
      .req_sample_z   (req_sample_z),
      .req_query_x    (req_query_x),
      .req_query_y    (req_query_y),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_status     (rsp_status),
      .rsp_exact_hit  (rsp_exact_hit)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while previous item still in work");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (!rsp_exact_hit && rsp_value == 16'sd0))
      else $error("empty set result carries a value or hit");

   a_emit_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_ready || $past(!req_ready))
      else $error("result appeared without any work cycle");

endmodule

>>> sim/inverse_distance_interpolator_tb.sv
module inverse_distance_interpolator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic               has_sample;
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic signed [15:0] sz;
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic               last;
      logic               hold_off;
   } sample_item_type;

   typedef struct {
      logic signed [15:0] value;
      logic               status;
      logic               exact_hit;
   } interp_result_type;

   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_has_sample = 1'b0;
   logic signed [15:0] req_sample_x = '0;
   logic signed [15:0] req_sample_y = '0;
   logic signed [15:0] req_sample_z = '0;
   logic signed [15:0] req_query_x = '0;
   logic signed [15:0] req_query_y = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_value;
   logic rsp_status;
   logic rsp_exact_hit;

   sample_item_type   pending_items[$];
   interp_result_type expected_results[$];
   bit                stimulus_done = 1'b0;
   int                error_count = 0;
   int                idle_cycles = 0;

   // predictor state
   logic [63:0]        acc_weighted;
   logic [48:0]        acc_weight;
   logic               hit_seen;
   logic signed [15:0] hit_z;
   logic signed [15:0] held_qx;
   logic signed [15:0] held_qy;
   logic               set_open;
   logic               sample_seen;

   inverse_distance_interpolator DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   function automatic logic [15:0] quotient_sat(logic [63:0] num, logic [48:0] den);
      logic        neg;
      logic [63:0] mag;
      logic [63:0] q;
      neg = num[63];
      mag = neg ? -num : num;
      q = mag / {15'd0, den};
      if (neg) begin
         if (q > 64'd32768) q = 64'd32768;
         return 16'(-q);
      end
      if (q > 64'd32767) q = 64'd32767;
      return q[15:0];
   endfunction

   task automatic predict_item(sample_item_type it);
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic [63:0]        d2;
      logic [63:0]        w;
      interp_result_type  res;
      if (!set_open) begin
         held_qx = it.qx;
         held_qy = it.qy;
         acc_weighted = '0;
         acc_weight = '0;
         hit_seen = 1'b0;
         hit_z = '0;
         sample_seen = 1'b0;
         set_open = 1'b1;
      end
      if (it.has_sample) begin
         sample_seen = 1'b1;
         if (!hit_seen) begin
            dx = 64'(it.sx) - 64'(held_qx);
            dy = 64'(it.sy) - 64'(held_qy);
            d2 = 64'(dx * dx) + 64'(dy * dy);
            if (d2 == 0) begin
               hit_seen = 1'b1;
               hit_z = it.sz;
            end else begin
               w = (64'd1 << 40) / d2;
               acc_weighted = acc_weighted + 64'($signed(it.sz)) * w;
               acc_weight = acc_weight + w[48:0];
            end
         end
      end
      if (it.last) begin
         res.value = '0;
         res.status = 1'b0;
         res.exact_hit = 1'b0;
         if (!sample_seen) res.status = 1'b1;
         else if (hit_seen) begin
            res.value = hit_z;
            res.exact_hit = 1'b1;
         end else if (acc_weight != 0) res.value = quotient_sat(acc_weighted, acc_weight);
         expected_results.push_back(res);
         set_open = 1'b0;
      end
   endtask

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(0, 20)) - 16'd10;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_item(logic hs, logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
                           logic [15:0] qx, logic [15:0] qy, logic lst, logic hold = 1'b0);
      sample_item_type it;
      it.has_sample = hs;
      it.sx = sx;
      it.sy = sy;
      it.sz = sz;
      it.qx = qx;
      it.qy = qy;
      it.last = lst;
      it.hold_off = hold;
      pending_items.push_back(it);
   endtask

   // driver
   int          req_gap = 0;
   logic        drv_hold = 1'b0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_item(pending_items.pop_front());
            req_gap <= gap_len();
            req_valid <= 1'b0;
         end else if (!req_valid) begin
            if (req_gap > 0) req_gap <= req_gap - 1;
            else if (pending_items.size() > 0 &&
                     !(pending_items[0].hold_off && expected_results.size() != 0)) begin
               req_valid <= 1'b1;
               req_has_sample <= pending_items[0].has_sample;
               req_sample_x <= pending_items[0].sx;
               req_sample_y <= pending_items[0].sy;
               req_sample_z <= pending_items[0].sz;
               req_query_x <= pending_items[0].qx;
               req_query_y <= pending_items[0].qy;
               req_last <= pending_items[0].last;
            end
         end
      end
   end

   // monitor
   int rsp_gap = 0;
   always @(posedge clock) begin
      interp_result_type exp_r;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result item value=%0d", rsp_value);
               error_count++;
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_value !== exp_r.value) begin
                  $error("value expected %0d actual %0d", exp_r.value, rsp_value);
                  error_count++;
               end
               if (rsp_status !== exp_r.status) begin
                  $error("status expected %0d actual %0d", exp_r.status, rsp_status);
                  error_count++;
               end
               if (rsp_exact_hit !== exp_r.exact_hit) begin
                  $error("exact_hit expected %0d actual %0d", exp_r.exact_hit, rsp_exact_hit);
                  error_count++;
               end
            end
            rsp_gap = gap_len();
         end
         if (rsp_gap > 0) begin
            rsp_ready <= 1'b0;
            rsp_gap = rsp_gap - 1;
         end else rsp_ready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else if (!stimulus_done) idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      int n;
      int set_len;
      int mode;
      logic [15:0] qx;
      logic [15:0] qy;
      set_open = 1'b0;
      acc_weighted = '0;
      acc_weight = '0;
      hit_seen = 1'b0;
      hit_z = '0;
      held_qx = '0;
      held_qy = '0;
      sample_seen = 1'b0;

      // directed: empty set, exact hits, extremes, far sample, saturation
      add_item(0, 0, 0, 0, 16'h0005, 16'h0006, 1);
      add_item(1, 16'h0005, 16'h0006, 16'h1234, 16'h0005, 16'h0006, 1);
      add_item(1, 16'h0001, 16'h0000, 16'h0064, 0, 0, 0);
      add_item(1, 0, 0, 16'h8000, 0, 0, 0);
      add_item(1, 0, 0, 16'h7fff, 0, 0, 1);
      add_item(1, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 1);
      add_item(1, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 0);
      add_item(1, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 1);
      add_item(1, 16'h0001, 0, 16'h7fff, 0, 0, 0);
      add_item(1, 16'hffff, 0, 16'h7fff, 0, 0, 0);
      add_item(0, 0, 0, 0, 16'h1111, 16'h2222, 1);
      add_item(1, 16'h0003, 16'h0004, 16'h8000, 0, 0, 0);
      add_item(1, 16'hfffd, 16'h0004, 16'h8000, 16'h7777, 16'h7777, 1);
      add_item(0, 0, 0, 0, 16'hffff, 16'hffff, 0);
      add_item(1, 16'h0010, 16'hfff0, 16'hffff, 0, 0, 1, 1);
      add_item(1, 16'h7fff, 16'h8000, 16'h0001, 16'h8000, 16'h7fff, 1);

      n = 16;
      while (n < 1950) begin
         mode = $urandom_range(0, 9);
         set_len = (mode == 0) ? 0 : $urandom_range(1, (mode < 8) ? 6 : 24);
         qx = rand_coord();
         qy = rand_coord();
         for (int i = 0; i < set_len; i++) begin
            if ($urandom_range(0, 15) == 0)
               add_item(1, qx, qy, 16'($urandom), 16'($urandom), 16'($urandom),
                        i == set_len - 1 && $urandom_range(0, 1));
            else if ($urandom_range(0, 3) == 0)
               add_item(1, qx + 16'($urandom_range(0, 6)) - 16'd3,
                        qy + 16'($urandom_range(0, 6)) - 16'd3, 16'($urandom),
                        16'($urandom), 16'($urandom), 0);
            else
               add_item($urandom_range(0, 9) != 0, rand_coord(), rand_coord(),
                        16'($urandom), (i == 0) ? qx : 16'($urandom),
                        (i == 0) ? qy : 16'($urandom), 0);
            n++;
         end
         add_item($urandom_range(0, 1), rand_coord(), rand_coord(), 16'($urandom),
                  (set_len == 0) ? qx : 16'($urandom), (set_len == 0) ? qy : 16'($urandom),
                  1, $urandom_range(0, 60) == 0);
         n++;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (pending_items.size() == 0 && !req_valid);
      wait (expected_results.size() == 0);
      stimulus_done = 1'b1;
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
